@@ sv/pidpos_pkg.sv @@
// Shared constants, register indexes and pipeline load strobes for the
// position PID step. No dependencies.
package pidpos_pkg;

  localparam int POSITION_WIDTH_DEF = 24;
  localparam int GAIN_FRAC_DEF      = 16;

  localparam int SUM_W      = 32;  // running error sum
  localparam int GAIN_W     = 20;  // unsigned gains
  localparam int ZONE_W     = 23;  // integral zone
  localparam int DRIVE_W    = 11;  // drive command and speed limits
  localparam int REG_IDX_W  = 3;
  localparam int OUT_TDATA_W = 16;

  localparam int DRIVE_MAX = (1 << (DRIVE_W - 1)) - 1;
  localparam int DRIVE_MIN = -(1 << (DRIVE_W - 1));

  // Register reset values
  localparam logic signed [DRIVE_W-1:0] MAX_SPEED_RST = DRIVE_W'(600);
  localparam logic signed [DRIVE_W-1:0] MIN_SPEED_RST = DRIVE_W'(0);
  localparam logic [GAIN_W-1:0]         GAIN_P_RST    = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0]         GAIN_I_RST    = GAIN_W'(0);
  localparam logic [GAIN_W-1:0]         GAIN_D_RST    = GAIN_W'(0);
  localparam logic [ZONE_W-1:0]         IZONE_RST     = ZONE_W'(10);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TARGET    = 3'd0,
    REG_MAX_SPEED = 3'd1,
    REG_MIN_SPEED = 3'd2,
    REG_GAIN_P    = 3'd3,
    REG_GAIN_I    = 3'd4,
    REG_GAIN_D    = 3'd5,
    REG_IZONE     = 3'd6
  } reg_idx_t;

  // One load strobe per pipeline register rank
  typedef struct packed {
    logic load_in;
    logic load_err;
    logic load_mul;
    logic load_scl;
    logic load_out;
  } pipe_ld_t;

endpackage

@@ sv/pid_position_step_izone_clamp.sv @@
// Top level of the position PID step with integral zone and speed limits.
// Depends on pidpos_pkg, pidpos_error and pidpos_drive.
//
// Usage:
//   Slave stream: one transaction per control tick. s_tuser carries the
//   restart flag (clears the error sum and previous error before the step),
//   s_tdata the two encoder positions. Master stream: one transaction per
//   input, the limited drive command and the done flag, in input order.
//   Config channel: cfg_addr selects the register (0 target, 1 max speed,
//   2 min speed, 3..5 gains P/I/D in Q4.16, 6 integral zone); other
//   indexes are dropped. cfg_ready is always high; write only while idle.
// Timing:
//   Five register ranks (input, error, products, sum, result). With
//   m_tready high a result moves through the ranks in that order onto
//   m_tvalid. One transaction per clock sustained while m_tready is high;
//   the error sum and previous error update in a loop within the error rank.
// Stall:
//   Each rank advances when the next one is empty or moving, so the
//   pipeline keeps filling while a result waits; s_tready drops only once
//   all five ranks hold items.
// Reset (rst, synchronous): empties the pipeline, clears the error sum and
//   previous error, and loads register defaults.
module pid_position_step_izone_clamp import pidpos_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
  input  logic clk,
  input  logic rst,
  // slave stream
  input  logic s_tvalid,
  output logic s_tready,
  // [P-1:0] position_a, [2P-1:P] position_b, rest zero
  input  logic [((2 * POSITION_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // [0] restart
  input  logic s_tuser,
  // master stream
  output logic m_tvalid,
  input  logic m_tready,
  // [10:0] drive, [11] done_res, [15:12] zero
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // config write channel
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [((POSITION_WIDTH > ZONE_W) ? POSITION_WIDTH : ZONE_W) - 1:0] cfg_data
);

  localparam int P = POSITION_WIDTH;

  // configuration registers
  logic signed [P-1:0]       target_position;
  logic signed [DRIVE_W-1:0] max_speed, min_speed;
  logic [GAIN_W-1:0]         gain_p, gain_i, gain_d;
  logic [ZONE_W-1:0]         integral_zone;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_position <= '0;
      max_speed       <= MAX_SPEED_RST;
      min_speed       <= MIN_SPEED_RST;
      gain_p          <= GAIN_P_RST;
      gain_i          <= GAIN_I_RST;
      gain_d          <= GAIN_D_RST;
      integral_zone   <= IZONE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_addr))
        REG_TARGET:    target_position <= cfg_data[P-1:0];
        REG_MAX_SPEED: max_speed       <= cfg_data[DRIVE_W-1:0];
        REG_MIN_SPEED: min_speed       <= cfg_data[DRIVE_W-1:0];
        REG_GAIN_P:    gain_p          <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:    gain_i          <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:    gain_d          <= cfg_data[GAIN_W-1:0];
        REG_IZONE:     integral_zone   <= cfg_data[ZONE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline occupancy, one valid bit per rank
  logic v_in, v_err, v_mul, v_scl;
  logic out_free, scl_free, mul_free, err_free, in_free;
  pipe_ld_t ld;

  assign out_free = !m_tvalid || m_tready;
  assign scl_free = !v_scl || out_free;
  assign mul_free = !v_mul || scl_free;
  assign err_free = !v_err || mul_free;
  assign in_free  = !v_in  || err_free;

  assign s_tready    = in_free;
  assign ld.load_in  = s_tvalid && in_free;
  assign ld.load_err = v_in  && err_free;
  assign ld.load_mul = v_err && mul_free;
  assign ld.load_scl = v_mul && scl_free;
  assign ld.load_out = v_scl && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in     <= 1'b0;
      v_err    <= 1'b0;
      v_mul    <= 1'b0;
      v_scl    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ld.load_in) begin
        v_in <= 1'b1;
      end else if (ld.load_err) begin
        v_in <= 1'b0;
      end
      if (ld.load_err) begin
        v_err <= 1'b1;
      end else if (ld.load_mul) begin
        v_err <= 1'b0;
      end
      if (ld.load_mul) begin
        v_mul <= 1'b1;
      end else if (ld.load_scl) begin
        v_mul <= 1'b0;
      end
      if (ld.load_scl) begin
        v_scl <= 1'b1;
      end else if (ld.load_out) begin
        v_scl <= 1'b0;
      end
      if (ld.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  logic signed [P:0]         err_q;
  logic signed [P+1:0]       deriv_q;
  logic signed [SUM_W-1:0]   acc_q;
  logic                      izone_q, done_q, done_res;
  logic signed [DRIVE_W-1:0] drive;

  pidpos_error #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_error (
    .clk        (clk),
    .rst        (rst),
    .ld         (ld),
    .restart    (s_tuser),
    .position_a (s_tdata[P-1:0]),
    .position_b (s_tdata[2*P-1:P]),
    .target     (target_position),
    .izone      (integral_zone),
    .err_q      (err_q),
    .deriv_q    (deriv_q),
    .acc_q      (acc_q),
    .izone_q    (izone_q),
    .done_q     (done_q)
  );

  pidpos_drive #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_drive (
    .clk       (clk),
    .ld        (ld),
    .err_q     (err_q),
    .deriv_q   (deriv_q),
    .acc_q     (acc_q),
    .izone_q   (izone_q),
    .done_q    (done_q),
    .gain_p    (gain_p),
    .gain_i    (gain_i),
    .gain_d    (gain_d),
    .max_speed (max_speed),
    .min_speed (min_speed),
    .drive     (drive),
    .done_res  (done_res)
  );

  assign m_tdata = {(OUT_TDATA_W - DRIVE_W - 1)'(0), done_res, drive};

endmodule

@@ sv/pidpos_error.sv @@
// Input register and error stage: averaging, error, saturating sum,
// derivative, integral-zone and done tests. Depends on pidpos_pkg.
module pidpos_error import pidpos_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pipe_ld_t                         ld,
  input  logic                             restart,
  input  logic signed [POSITION_WIDTH-1:0] position_a,
  input  logic signed [POSITION_WIDTH-1:0] position_b,
  input  logic signed [POSITION_WIDTH-1:0] target,
  input  logic [ZONE_W-1:0]                izone,
  output logic signed [POSITION_WIDTH:0]   err_q,
  output logic signed [POSITION_WIDTH+1:0] deriv_q,
  output logic signed [SUM_W-1:0]          acc_q,
  output logic                             izone_q,
  output logic                             done_q
);

  localparam int P  = POSITION_WIDTH;
  localparam int AW = ((P + 1 > SUM_W) ? P + 1 : SUM_W) + 1;
  localparam int ZW = ((P + 1 > ZONE_W + 1) ? P + 1 : ZONE_W + 1) + 1;

  localparam logic signed [AW-1:0] SUM_MAX_W = {{(AW - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
  localparam logic signed [AW-1:0] SUM_MIN_W = {{(AW - SUM_W + 1){1'b1}}, {(SUM_W - 1){1'b0}}};
  localparam logic signed [P+1:0]  ONE_E     = (P + 2)'(1);

  // state carried across items
  logic signed [SUM_W-1:0] error_sum;
  logic signed [P:0]       previous_error;

  // input register
  logic                restart_in;
  logic signed [P-1:0] avg_in;

  logic signed [P:0] sum2, sum_half, avg_w;
  logic              avg_corr;

  // average truncated toward zero
  assign sum2     = {position_a[P-1], position_a} + {position_b[P-1], position_b};
  assign sum_half = sum2 >>> 1;
  assign avg_corr = sum2[P] & sum2[0];
  assign avg_w    = sum_half + $signed((P + 1)'(avg_corr));

  always_ff @(posedge clk) begin
    if (ld.load_in) begin
      restart_in <= restart;
      avg_in     <= avg_w[P-1:0];
    end
  end

  logic signed [P:0]       err_w, prev_use;
  logic signed [SUM_W-1:0] sum_use, acc_sat;
  logic signed [AW-1:0]    acc_w;
  logic signed [P+1:0]     deriv_w, avg_e, abs_avg, tgt_e, abs_tgt;
  logic signed [ZW-1:0]    err_z, zone_z;
  logic                    zone_hit, done_w;

  assign err_w    = {target[P-1], target} - {avg_in[P-1], avg_in};
  assign sum_use  = restart_in ? '0 : error_sum;
  assign prev_use = restart_in ? '0 : previous_error;

  assign acc_w = AW'(sum_use) + AW'(err_w);
  always_comb begin
    if (acc_w > SUM_MAX_W) begin
      acc_sat = SUM_MAX_W[SUM_W-1:0];
    end else if (acc_w < SUM_MIN_W) begin
      acc_sat = SUM_MIN_W[SUM_W-1:0];
    end else begin
      acc_sat = acc_w[SUM_W-1:0];
    end
  end

  assign deriv_w = (P + 2)'(err_w) - (P + 2)'(prev_use);

  assign err_z    = ZW'(err_w);
  assign zone_z   = $signed(ZW'(izone));
  assign zone_hit = (err_z <= zone_z) && (err_z >= -zone_z);

  assign avg_e   = (P + 2)'(avg_in);
  assign abs_avg = (avg_e < 0) ? -avg_e : avg_e;
  assign tgt_e   = (P + 2)'(target);
  assign abs_tgt = (tgt_e < 0) ? -tgt_e : tgt_e;
  assign done_w  = abs_avg >= (abs_tgt - ONE_E);

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (ld.load_err) begin
      error_sum      <= acc_sat;
      previous_error <= err_w;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load_err) begin
      err_q   <= err_w;
      deriv_q <= deriv_w;
      acc_q   <= acc_sat;
      izone_q <= zone_hit;
      done_q  <= done_w;
    end
  end

endmodule

@@ sv/pidpos_drive.sv @@
// Gain products, truncating scale-down, sum and speed limiting into the
// result register. Depends on pidpos_pkg.
module pidpos_drive import pidpos_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
  input  logic                             clk,
  input  pipe_ld_t                         ld,
  input  logic signed [POSITION_WIDTH:0]   err_q,
  input  logic signed [POSITION_WIDTH+1:0] deriv_q,
  input  logic signed [SUM_W-1:0]          acc_q,
  input  logic                             izone_q,
  input  logic                             done_q,
  input  logic [GAIN_W-1:0]                gain_p,
  input  logic [GAIN_W-1:0]                gain_i,
  input  logic [GAIN_W-1:0]                gain_d,
  input  logic signed [DRIVE_W-1:0]        max_speed,
  input  logic signed [DRIVE_W-1:0]        min_speed,
  output logic signed [DRIVE_W-1:0]        drive,
  output logic                             done_res
);

  localparam int P   = POSITION_WIDTH;
  localparam int F   = GAIN_FRAC_BITS;
  localparam int PW  = P + 1 + GAIN_W + 1;
  localparam int DW  = P + 2 + GAIN_W + 1;
  localparam int IPW = SUM_W + GAIN_W + 1;
  localparam int PDW = DW + 1;
  localparam int TW  = ((PDW > IPW) ? PDW : IPW) + 1;

  localparam logic signed [TW-1:0] DRV_HI = TW'(DRIVE_MAX);
  localparam logic signed [TW-1:0] DRV_LO = TW'(DRIVE_MIN);

  logic signed [GAIN_W:0] gp_s, gi_s, gd_s;
  assign gp_s = $signed({1'b0, gain_p});
  assign gi_s = $signed({1'b0, gain_i});
  assign gd_s = $signed({1'b0, gain_d});

  // product rank
  logic signed [PW-1:0]  pterm_q;
  logic signed [DW-1:0]  dterm_q;
  logic signed [IPW-1:0] iprod_q;
  logic                  done_m;

  always_ff @(posedge clk) begin
    if (ld.load_mul) begin
      pterm_q <= PW'(err_q) * PW'(gp_s);
      dterm_q <= DW'(deriv_q) * DW'(gd_s);
      iprod_q <= izone_q ? IPW'(acc_q) * IPW'(gi_s) : '0;
      done_m  <= done_q;
    end
  end

  // sum rank: P+D sum, integral scaled toward zero
  logic signed [PDW-1:0] pd_w, pd_q;
  logic signed [IPW-1:0] iprod_sh, iscl_w, iscl_q;
  logic                  icorr, done_s;

  assign pd_w     = PDW'(pterm_q) + PDW'(dterm_q);
  assign iprod_sh = iprod_q >>> F;
  assign icorr    = iprod_q[IPW-1] & (|iprod_q[F-1:0]);
  assign iscl_w   = iprod_sh + $signed(IPW'(icorr));

  always_ff @(posedge clk) begin
    if (ld.load_scl) begin
      pd_q   <= pd_w;
      iscl_q <= iscl_w;
      done_s <= done_m;
    end
  end

  // limit rank
  logic signed [PDW-1:0]  pd_sh;
  logic                   pcorr, over_max, under_min;
  logic signed [TW-1:0]   total, mx_e, mn_e, amx, amn;
  logic signed [DRIVE_W-1:0] drive_next;

  assign pd_sh = pd_q >>> F;
  assign pcorr = pd_q[PDW-1] & (|pd_q[F-1:0]);
  assign total = TW'(pd_sh) + TW'(iscl_q) + $signed(TW'(pcorr));

  assign mx_e = TW'(max_speed);
  assign mn_e = TW'(min_speed);
  assign amx  = (mx_e < 0) ? -mx_e : mx_e;
  assign amn  = (mn_e < 0) ? -mn_e : mn_e;

  assign over_max  = (total > amx) || (total < -amx);
  assign under_min = (total < amn) && (total > -amn);

  always_comb begin
    if (over_max) begin
      drive_next = max_speed;
    end else if (under_min) begin
      drive_next = min_speed;
    end else if (total > DRV_HI) begin
      drive_next = DRIVE_W'(DRIVE_MAX);
    end else if (total < DRV_LO) begin
      drive_next = DRIVE_W'(DRIVE_MIN);
    end else begin
      drive_next = total[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load_out) begin
      drive    <= drive_next;
      done_res <= done_s;
    end
  end

endmodule

@@ sv/pidpos_check.sv @@
// Port-level checker for the position PID step, bound to the top level.
// Depends on pidpos_pkg.
module pidpos_check import pidpos_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int DEPTH = 5;

  // transactions accepted but not yet delivered
  logic [2:0] pending;
  logic       in_acc, out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 3'd0)
    else $error("result without a pending input");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'(DEPTH))
    else $error("more items in flight than pipeline ranks");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    pending == 3'd0 |-> s_tready)
    else $error("input stalled with empty pipeline");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind pid_position_step_izone_clamp pidpos_check u_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
